### rtl/hdlcft_pkg.sv
// Shared types, constants and functions of the HDLC frame transmitter.
`timescale 1ns / 1ps

package hdlcft_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] FCS_POLY  = 16'h8408;
    localparam logic [15:0] FCS_INIT  = 16'hFFFF;
    localparam logic [9:0]  COUNT_MAX = 10'd1023;
    localparam int unsigned FCS_CHECK_MIN = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       run_last;
        logic [9:0] frame_bytes;
    } t_out;

    // One classified request handed from the front to the back
    typedef struct packed {
        logic [7:0]  data;
        logic        esc_data;
        logic [15:0] fcs;
        logic        esc_lo;
        logic        esc_hi;
        logic        last;
        logic        open;
    } t_cmd;

    typedef enum logic [4:0] {
        PH_OPEN   = 5'b00001,
        PH_DATA   = 5'b00010,
        PH_FCS_LO = 5'b00100,
        PH_FCS_HI = 5'b01000,
        PH_CLOSE  = 5'b10000
    } t_phase;

    function automatic logic f_needs_esc(input logic [7:0] b);
        f_needs_esc = (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    function automatic logic [15:0] f_fcs_update(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] acc;
        acc = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (acc[0]) begin
                acc = (acc >> 1) ^ FCS_POLY;
            end else begin
                acc = acc >> 1;
            end
        end
        f_fcs_update = acc;
    endfunction

endpackage

### rtl/hdlcft_front.sv
// Front end: frame tracking, FCS accumulation and escape classification.
`timescale 1ns / 1ps

module hdlcft_front
    import hdlcft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_in,
    output t_cmd o_cmd
);

    logic [15:0] r_fcs, n_fcs;
    logic        r_in_frame, n_in_frame;
    logic [15:0] fcs_base;
    logic [15:0] fcs_new;
    logic [15:0] fcs_final;

    assign fcs_base  = r_in_frame ? r_fcs : FCS_INIT;
    assign fcs_new   = f_fcs_update(fcs_base, i_in.data_byte);
    assign fcs_final = ~fcs_new;

    always_comb begin
        n_fcs      = r_fcs;
        n_in_frame = r_in_frame;
        if (i_accept) begin
            if (i_in.last_byte) begin
                n_fcs      = FCS_INIT;
                n_in_frame = 1'b0;
            end else begin
                n_fcs      = fcs_new;
                n_in_frame = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcs      <= FCS_INIT;
            r_in_frame <= 1'b0;
        end else begin
            r_fcs      <= n_fcs;
            r_in_frame <= n_in_frame;
        end
    end

    always_comb begin
        o_cmd.data     = i_in.data_byte;
        o_cmd.esc_data = f_needs_esc(i_in.data_byte);
        o_cmd.fcs      = fcs_final;
        o_cmd.esc_lo   = f_needs_esc(fcs_final[7:0]);
        o_cmd.esc_hi   = f_needs_esc(fcs_final[15:8]);
        o_cmd.last     = i_in.last_byte;
        o_cmd.open     = !r_in_frame;
    end

endmodule

### rtl/hdlcft_cmdq.sv
// Short request queue between front and back ends.
`timescale 1ns / 1ps

module hdlcft_cmdq
    import hdlcft_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_valid,
    output logic o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### rtl/hdlcft_back.sv
// Back end: line byte sequencer with byte stuffing and output register.
`timescale 1ns / 1ps

module hdlcft_back
    import hdlcft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_cmd_valid,
    output logic o_cmd_pop,
    output t_out o_out,
    output logic o_empty,
    input  logic i_pop
);

    t_phase     r_phase, n_phase;
    t_phase     phase;
    logic       r_half, n_half;
    logic [9:0] r_count, n_count;
    t_out       r_out, n_out;
    logic       r_ov, n_ov;
    logic       adv;
    logic [7:0] sel_byte;
    logic       sel_esc;
    logic       sel_done;
    logic [9:0] total;

    // The opening flag is skipped when the frame is already open
    assign phase = (r_phase == PH_OPEN && !i_cmd.open) ? PH_DATA : r_phase;
    assign adv   = i_cmd_valid && (!r_ov || i_pop);
    assign total = (r_count < COUNT_MAX) ? r_count + 10'd1 : COUNT_MAX;

    always_comb begin
        sel_byte = i_cmd.data;
        sel_esc  = i_cmd.esc_data;
        unique case (phase)
            PH_FCS_LO: begin
                sel_byte = i_cmd.fcs[7:0];
                sel_esc  = i_cmd.esc_lo;
            end
            PH_FCS_HI: begin
                sel_byte = i_cmd.fcs[15:8];
                sel_esc  = i_cmd.esc_hi;
            end
            default: begin
                sel_byte = i_cmd.data;
                sel_esc  = i_cmd.esc_data;
            end
        endcase
    end

    // Second half of an escape pair, or a plain byte, finishes the slot
    assign sel_done = !sel_esc || r_half;

    always_comb begin
        n_phase   = r_phase;
        n_half    = r_half;
        n_count   = r_count;
        n_out     = r_out;
        n_ov      = r_ov;
        o_cmd_pop = 1'b0;
        if (adv) begin
            n_ov              = 1'b1;
            n_out.run_last    = 1'b0;
            n_out.frame_bytes = '0;
            n_count           = (r_count < COUNT_MAX) ? r_count + 10'd1 : COUNT_MAX;
            n_out.tx_byte     = sel_byte;
            if (sel_esc) begin
                n_out.tx_byte = r_half ? (sel_byte ^ ESC_XOR) : ESC_BYTE;
                n_half        = !r_half;
            end
            unique case (phase)
                PH_OPEN: begin
                    n_out.tx_byte = FLAG_BYTE;
                    n_half        = 1'b0;
                    n_count       = 10'd1;
                    n_phase       = PH_DATA;
                end
                PH_DATA: begin
                    if (sel_done) begin
                        if (i_cmd.last) begin
                            n_phase = PH_FCS_LO;
                        end else begin
                            n_phase        = PH_OPEN;
                            n_out.run_last = 1'b1;
                            o_cmd_pop      = 1'b1;
                        end
                    end
                end
                PH_FCS_LO: begin
                    if (sel_done) begin
                        n_phase = PH_FCS_HI;
                    end
                end
                PH_FCS_HI: begin
                    if (sel_done) begin
                        n_phase = PH_CLOSE;
                    end
                end
                PH_CLOSE: begin
                    n_out.tx_byte     = FLAG_BYTE;
                    n_out.run_last    = 1'b1;
                    n_out.frame_bytes = total;
                    n_half            = 1'b0;
                    n_count           = '0;
                    n_phase           = PH_OPEN;
                    o_cmd_pop         = 1'b1;
                end
                default: begin
                    n_phase = PH_OPEN;
                end
            endcase
        end else if (i_pop) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPEN;
            r_half  <= 1'b0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_half  <= n_half;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out   = r_out;
    assign o_empty = !r_ov;

    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_ov && r_out.run_last))
        else $error("request retired without marking its final byte");

    a_total_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.frame_bytes != '0) |-> (r_out.run_last && r_out.tx_byte == FLAG_BYTE))
        else $error("frame byte count outside closing flag");

    a_close_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && phase == PH_CLOSE) |-> (r_count >= 10'(FCS_CHECK_MIN)))
        else $error("closing flag with too few bytes sent");

    a_half_only_escaped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> (phase == PH_DATA || phase == PH_FCS_LO || phase == PH_FCS_HI))
        else $error("escape pair open outside a stuffed slot");

endmodule

### rtl/hdlc_frame_transmitter_unit.sv
// Top level of the HDLC frame transmitter.
`timescale 1ns / 1ps

// Usage:
//   Input queue side: drive i_in (data_byte, last_byte) and raise push; the
//   request is taken on a rising edge with push high and full low. Set
//   last_byte on the final payload byte of each frame.
//   Output queue side: while empty is low, o_out holds the oldest line byte
//   (tx_byte, run_last, frame_bytes); pop takes it on a rising edge.
//   Each request yields 1 to 8 line bytes: opening flag on the first byte of
//   a frame, stuffed data, and on the last byte the stuffed FCS-16 and the
//   closing flag, which carries the frame's total byte count.
//   A taken request is written into the request queue; its first line byte
//   is then registered into the output register, once that is free.
//   The back end sequencer emits one line byte per cycle while a request
//   waits and the output register is free or being popped, so a request
//   holds it for as many line bytes as it makes; the request queue of
//   CMD_DEPTH entries absorbs the difference.
//   Reset (synchronous, active low) empties both queues and closes any open
//   frame. When the receiver stops popping, the output register holds,
//   the request queue fills and full rises.

module hdlc_frame_transmitter_unit
    import hdlcft_pkg::*;
#(
    parameter int CMD_DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_in,
    output logic empty,
    input  logic pop,
    output t_out o_out
);

    logic accept;
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic q_valid;
    logic q_full;
    logic q_pop;

    assign accept = push && !q_full;
    assign full   = q_full;

    hdlcft_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_cmd    (front_cmd)
    );

    hdlcft_cmdq #(
        .DEPTH (CMD_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    hdlcft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .o_out       (o_out),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

### tb/hdlc_frame_checker.sv
// Checker for the HDLC frame transmitter: predicts the line bytes of each request and compares.
`timescale 1ns / 1ps

module hdlc_frame_checker
    import hdlcft_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_full,
    input  t_in  i_req,
    input  logic i_empty,
    input  logic i_pop,
    input  t_out i_line,
    output int   o_fail_count,
    output int   o_pending
);

    logic [15:0] fcs_run;
    logic        frame_open;
    logic [9:0]  line_count;
    t_out        step_q[$];
    t_out        expected_line_q[$];
    t_out        want;
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void line_emit(input logic [7:0] b, input logic [9:0] total);
        t_out r;
        r.tx_byte     = b;
        r.run_last    = 1'b0;
        r.frame_bytes = total;
        step_q.push_back(r);
        if (line_count != COUNT_MAX) begin
            line_count = line_count + 10'd1;
        end
    endfunction

    function automatic void line_emit_stuffed(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            line_emit(ESC_BYTE, '0);
            line_emit(b ^ ESC_XOR, '0);
        end else begin
            line_emit(b, '0);
        end
    endfunction

    // Bitwise reflected CRC-16, LSB first
    function automatic logic [15:0] fcs16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        acc = crc ^ {8'h00, b};
        repeat (8) begin
            acc = acc[0] ? ((acc >> 1) ^ FCS_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    task automatic frame_encode(input t_in req);
        logic [15:0] fcs_out;
        logic [9:0]  total;
        t_out        tail;
        step_q.delete();
        if (!frame_open) begin
            line_count = '0;
            fcs_run    = FCS_INIT;
            line_emit(FLAG_BYTE, '0);
            frame_open = 1'b1;
        end
        line_emit_stuffed(req.data_byte);
        fcs_run = fcs16_next(fcs_run, req.data_byte);
        if (req.last_byte) begin
            fcs_out = ~fcs_run;
            line_emit_stuffed(fcs_out[7:0]);
            line_emit_stuffed(fcs_out[15:8]);
            // closing flag counts itself; count sticks at its ceiling
            total = (line_count != COUNT_MAX) ? line_count + 10'd1 : COUNT_MAX;
            line_emit(FLAG_BYTE, total);
            fcs_run    = FCS_INIT;
            frame_open = 1'b0;
            line_count = '0;
        end
        tail          = step_q.pop_back();
        tail.run_last = 1'b1;
        step_q.push_back(tail);
        foreach (step_q[k]) begin
            expected_line_q.push_back(step_q[k]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fcs_run    = FCS_INIT;
            frame_open = 1'b0;
            line_count = '0;
            expected_line_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_line_q.size() == 0) begin
                    $error("unexpected line byte %0h", i_line.tx_byte);
                    mismatches++;
                end else begin
                    want = expected_line_q.pop_front();
                    if (i_line.tx_byte !== want.tx_byte) begin
                        $error("tx_byte: expected %0h, actual %0h",
                               want.tx_byte, i_line.tx_byte);
                        mismatches++;
                    end
                    if (i_line.run_last !== want.run_last) begin
                        $error("run_last: expected %0d, actual %0d",
                               want.run_last, i_line.run_last);
                        mismatches++;
                    end
                    if (i_line.frame_bytes !== want.frame_bytes) begin
                        $error("frame_bytes: expected %0d, actual %0d",
                               want.frame_bytes, i_line.frame_bytes);
                        mismatches++;
                    end
                end
            end
            if (i_push && !i_full) begin
                frame_encode(i_req);
            end
        end
        o_pending <= expected_line_q.size();
    end

endmodule

### tb/tb_hdlc_frame_transmitter_unit.sv
// Testbench top for the HDLC frame transmitter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_hdlc_frame_transmitter_unit;
    import hdlcft_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_in  i_in    = '0;
    logic full;
    logic empty;
    t_out o_out;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count;
    int pending;
    int quiet_cycles   = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    hdlc_frame_transmitter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_in    (i_in),
        .empty   (empty),
        .pop     (pop),
        .o_out   (o_out)
    );

    hdlc_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_req        (i_in),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_line       (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: no request moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Entered just after an edge; returns on the edge that takes the request
    task automatic send_req(input logic [7:0] d, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= {d, l};
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_frame(input int len, input int esc_pct);
        logic [7:0] b;
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(99) < esc_pct) begin
                b = $urandom_range(1) ? FLAG_BYTE : ESC_BYTE;
            end else begin
                b = 8'($urandom_range(255));
            end
            send_req(b, n == len - 1);
        end
    endtask

    initial begin
        int sent;
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one-byte frames at the extremes and both stuffed values
        send_req(8'h00, 1'b1);
        send_req(8'hFF, 1'b1);
        send_req(FLAG_BYTE, 1'b1);
        send_req(ESC_BYTE, 1'b1);
        // stuffed bytes next to their unstuffed lookalikes
        send_req(8'h5E, 1'b0);
        send_req(FLAG_BYTE, 1'b0);
        send_req(ESC_BYTE, 1'b0);
        send_req(8'h5D, 1'b0);
        send_req(8'hFF, 1'b0);
        send_req(8'h00, 1'b1);
        // a long run of escapes only
        send_frame(100, 100);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            sent = 0;
            while (sent < 70) begin
                len = ($urandom_range(99) < 40) ? 1 : $urandom_range(12, 2);
                send_frame(len, 20);
                sent += len;
            end
        end
        push <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
